/* rtl/lzss_pkg.sv */
// ----------------------------------------------------------------------------
// LZSS decoder package
// Shared constants, sequencer state type and the byte transfer structure
// used between the token sequencer and the output packer.
// ----------------------------------------------------------------------------
`default_nettype none

package lzss_pkg;

   localparam int HISTORY_DEPTH    = 32768;
   localparam int ADDR_W           = $clog2(HISTORY_DEPTH);
   localparam int BYTES_PER_RESULT = 8;
   localparam int OUT_W            = 8 * BYTES_PER_RESULT;
   localparam int CNT_W            = 4;
   localparam int RUN_W            = 9;
   localparam int TOKEN_W          = 4;

   localparam logic [RUN_W-1:0]   MIN_MATCH    = RUN_W'(3);
   localparam logic [TOKEN_W-1:0] GROUP_TOKENS = TOKEN_W'(8);

   localparam logic [1:0] PH_TOKEN   = 2'd0;
   localparam logic [1:0] PH_DIST_HI = 2'd1;
   localparam logic [1:0] PH_LENGTH  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COPY
   } lzss_state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } lzss_push_type;

endpackage

`default_nettype wire

/* rtl/lzss_req_if.sv */
// ----------------------------------------------------------------------------
// LZSS request channel
// Valid/ready channel that carries one compressed stream byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

/* rtl/lzss_rsp_if.sv */
// ----------------------------------------------------------------------------
// LZSS response channel
// Valid/ready channel that carries up to eight decoded bytes per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzss_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lzss_pkg::OUT_W-1:0] out_bytes;
   logic [lzss_pkg::CNT_W-1:0] byte_count;
   logic                      last_of_run;

   modport source (output valid, output out_bytes, output byte_count,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_bytes, input byte_count,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/lzss_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/lzss_packer.sv */
// ----------------------------------------------------------------------------
// LZSS output packer
// Gathers decoded bytes into words of up to eight bytes and holds each
// finished word in an output register until the response transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_packer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lzss_pkg::lzss_push_type push,
   output logic                         push_ready,
   lzss_rsp_if.source                   rsp_chan
);

   localparam logic [lzss_pkg::CNT_W-1:0] FULL_CNT =
      lzss_pkg::CNT_W'(lzss_pkg::BYTES_PER_RESULT - 1);

   logic [lzss_pkg::OUT_W-1:0] acc_ff, acc_in, merged;
   logic [lzss_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       out_valid_ff, out_valid_in;
   logic [lzss_pkg::OUT_W-1:0] out_bytes_ff, out_bytes_in;
   logic [lzss_pkg::CNT_W-1:0] out_count_ff, out_count_in;
   logic                       out_last_ff, out_last_in;
   logic                       can_take, completes;

   assign can_take   = !out_valid_ff || rsp_chan.ready;
   assign completes  = (cnt_ff == FULL_CNT) || push.last;
   assign push_ready = !completes || can_take;

   always_comb begin
      merged = acc_ff;
      for (int i = 0; i < lzss_pkg::BYTES_PER_RESULT; i++) begin
         if (cnt_ff == lzss_pkg::CNT_W'(i)) begin
            merged[i*8 +: 8] = push.data;
         end
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_bytes_in = out_bytes_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;
      if (push.valid && completes) begin
         out_valid_in = 1'b1;
         out_bytes_in = merged;
         out_count_in = cnt_ff + 1'b1;
         out_last_in  = push.last;
         acc_in       = '0;
         cnt_in       = '0;
      end else if (push.valid) begin
         acc_in = merged;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      out_bytes_ff <= out_bytes_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_bytes   = out_bytes_ff;
   assign rsp_chan.byte_count  = out_count_ff;
   assign rsp_chan.last_of_run = out_last_ff;

endmodule

`default_nettype wire

/* rtl/lzss_token_stream_decoder.sv */
// ----------------------------------------------------------------------------
// LZSS token stream decoder
// Parses flag, literal and match bytes and replays matches from a 32 KiB
// history window, emitting decoded bytes packed up to eight to a response.
// ----------------------------------------------------------------------------
// Flag bytes, literal bytes and the first two bytes of a match are taken one
// per cycle; a literal also needs room in the output register. The length byte
// of a match holds off further requests until the whole copy is done, since
// every copied byte passes through a read state and a write state on the single
// window memory, and the write state also waits while the response side stalls.
`default_nettype none

module lzss_token_stream_decoder (
   input  wire logic  clock,
   input  wire logic  reset,
   lzss_req_if.sink   req_chan,
   lzss_rsp_if.source rsp_chan
);

   localparam int AW = lzss_pkg::ADDR_W;

   lzss_pkg::lzss_state_type state_ff, state_in;

   logic [AW-1:0]                    wp_ff, wp_in;
   logic [7:0]                       flags_ff, flags_in;
   logic [lzss_pkg::TOKEN_W-1:0]     tokens_ff, tokens_in;
   logic [1:0]                       phase_ff, phase_in;
   logic [7:0]                       dist_lo_ff, dist_lo_in;
   logic [7:0]                       dist_hi_ff, dist_hi_in;
   logic [lzss_pkg::RUN_W-1:0]       remain_ff, remain_in;

   logic [15:0]            dist_m1;
   logic [AW-1:0]          rd_addr;
   logic [7:0]             rd_data;
   logic                   wr_en;
   logic [7:0]             wr_data;
   logic                   is_literal;
   logic                   req_fire;
   logic                   pk_ready;
   lzss_pkg::lzss_push_type push;

   assign dist_m1    = {dist_hi_ff, dist_lo_ff};
   assign rd_addr    = wp_ff - AW'(1) - dist_m1[AW-1:0];
   assign is_literal = (tokens_ff != '0) && (phase_ff == lzss_pkg::PH_TOKEN)
                       && flags_ff[0];

   assign req_chan.ready = (state_ff == lzss_pkg::ST_IDLE) && (!is_literal || pk_ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzss_pkg::ST_IDLE: begin
            if (req_fire && (tokens_ff != '0) && (phase_ff == lzss_pkg::PH_LENGTH)) begin
               state_in = lzss_pkg::ST_READ;
            end
         end
         lzss_pkg::ST_READ: begin
            state_in = lzss_pkg::ST_COPY;
         end
         lzss_pkg::ST_COPY: begin
            if (pk_ready) begin
               state_in = (remain_ff == lzss_pkg::RUN_W'(1)) ? lzss_pkg::ST_IDLE
                                                            : lzss_pkg::ST_READ;
            end
         end
         default: begin
            state_in = lzss_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      wp_in      = wp_ff;
      flags_in   = flags_ff;
      tokens_in  = tokens_ff;
      phase_in   = phase_ff;
      dist_lo_in = dist_lo_ff;
      dist_hi_in = dist_hi_ff;
      remain_in  = remain_ff;
      wr_en      = 1'b0;
      wr_data    = req_chan.data_byte;
      push.valid = 1'b0;
      push.data  = req_chan.data_byte;
      push.last  = 1'b1;
      case (state_ff)
         lzss_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (tokens_ff == '0) begin
                  flags_in  = req_chan.data_byte;
                  tokens_in = lzss_pkg::GROUP_TOKENS;
                  phase_in  = lzss_pkg::PH_TOKEN;
               end else begin
                  case (phase_ff)
                     lzss_pkg::PH_TOKEN: begin
                        if (flags_ff[0]) begin
                           wr_en      = 1'b1;
                           push.valid = 1'b1;
                           wp_in      = wp_ff + AW'(1);
                           flags_in   = flags_ff >> 1;
                           tokens_in  = tokens_ff - 1'b1;
                        end else begin
                           dist_lo_in = req_chan.data_byte;
                           phase_in   = lzss_pkg::PH_DIST_HI;
                        end
                     end
                     lzss_pkg::PH_DIST_HI: begin
                        dist_hi_in = req_chan.data_byte;
                        phase_in   = lzss_pkg::PH_LENGTH;
                     end
                     default: begin
                        remain_in = {1'b0, req_chan.data_byte} + lzss_pkg::MIN_MATCH;
                     end
                  endcase
               end
            end
         end
         lzss_pkg::ST_COPY: begin
            wr_data   = rd_data;
            push.data = rd_data;
            push.last = (remain_ff == lzss_pkg::RUN_W'(1));
            if (pk_ready) begin
               wr_en      = 1'b1;
               push.valid = 1'b1;
               wp_in      = wp_ff + AW'(1);
               remain_in  = remain_ff - 1'b1;
               if (remain_ff == lzss_pkg::RUN_W'(1)) begin
                  flags_in  = flags_ff >> 1;
                  tokens_in = tokens_ff - 1'b1;
                  phase_in  = lzss_pkg::PH_TOKEN;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lzss_pkg::ST_IDLE;
         wp_ff      <= '0;
         flags_ff   <= '0;
         tokens_ff  <= '0;
         phase_ff   <= lzss_pkg::PH_TOKEN;
         dist_lo_ff <= '0;
         dist_hi_ff <= '0;
         remain_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         flags_ff   <= flags_in;
         tokens_ff  <= tokens_in;
         phase_ff   <= phase_in;
         dist_lo_ff <= dist_lo_in;
         dist_hi_ff <= dist_hi_in;
         remain_ff  <= remain_in;
      end
   end

   lzss_ram #(
      .WIDTH (8),
      .DEPTH (lzss_pkg::HISTORY_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lzss_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (pk_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

/* test/lzss_token_stream_decoder_test.sv */
// ----------------------------------------------------------------------------
// LZSS token stream decoder testbench
// Feeds well-formed compressed streams (directed extremes, then random groups
// of literals and matches) through the request channel with random idle
// bursts on both sides, predicts the decoded byte packing in a scoreboard and
// checks every response transaction field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_token_stream_decoder_test;

   localparam int STREAM_TARGET = 170;
   localparam int CALM_TAIL     = 25;
   localparam int DRAIN_CYCLES  = 600;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   class lzss_decode_scoreboard;
      typedef struct packed {
         logic [lzss_pkg::OUT_W-1:0] bytes;
         logic [lzss_pkg::CNT_W-1:0] count;
         logic                       last;
      } decoded_word_type;

      bit [7:0]                  window_mem [lzss_pkg::HISTORY_DEPTH];
      bit [lzss_pkg::ADDR_W-1:0] wr_ptr;
      bit [7:0]                  flag_bits;
      int unsigned               tokens_left;
      logic [1:0]                phase;
      bit [7:0]                  dist_lo;
      bit [7:0]                  dist_hi;
      decoded_word_type          expected_q [$];
      int unsigned               error_count;

      function new();
         wr_ptr      = '0;
         flag_bits   = '0;
         tokens_left = 0;
         phase       = lzss_pkg::PH_TOKEN;
         dist_lo     = '0;
         dist_hi     = '0;
         error_count = 0;
      endfunction

      function void store_byte(bit [7:0] value);
         window_mem[wr_ptr] = value;
         wr_ptr = wr_ptr + 1'b1;
      endfunction

      function void close_token();
         flag_bits = flag_bits >> 1;
         if (tokens_left > 0) tokens_left--;
         phase = lzss_pkg::PH_TOKEN;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_input(bit [7:0] value);
         bit [7:0]                  run [$];
         bit [lzss_pkg::ADDR_W-1:0] dist_m1;
         bit [lzss_pkg::ADDR_W-1:0] slot;
         bit [7:0]                  copied;
         int unsigned               copy_len;
         int unsigned               pos;
         int unsigned               cnt;
         decoded_word_type          word;
         if (tokens_left == 0) begin
            flag_bits   = value;
            tokens_left = lzss_pkg::GROUP_TOKENS;
            phase       = lzss_pkg::PH_TOKEN;
            return;
         end
         case (phase)
            lzss_pkg::PH_TOKEN: begin
               if (flag_bits[0]) begin
                  run.push_back(value);
                  store_byte(value);
                  close_token();
               end else begin
                  dist_lo = value;
                  phase   = lzss_pkg::PH_DIST_HI;
               end
            end
            lzss_pkg::PH_DIST_HI: begin
               dist_hi = value;
               phase   = lzss_pkg::PH_LENGTH;
            end
            default: begin
               dist_m1  = lzss_pkg::ADDR_W'({dist_hi, dist_lo});
               copy_len = int'(value) + int'(lzss_pkg::MIN_MATCH);
               for (int i = 0; i < copy_len; i++) begin
                  slot   = wr_ptr - lzss_pkg::ADDR_W'(1) - dist_m1;
                  copied = window_mem[slot];
                  run.push_back(copied);
                  store_byte(copied);
               end
               close_token();
            end
         endcase
         pos = 0;
         while (pos < run.size()) begin
            cnt = run.size() - pos;
            if (cnt > lzss_pkg::BYTES_PER_RESULT) cnt = lzss_pkg::BYTES_PER_RESULT;
            word = '0;
            for (int i = 0; i < cnt; i++) begin
               word.bytes[8*i +: 8] = run[pos + i];
            end
            pos += cnt;
            word.count = lzss_pkg::CNT_W'(cnt);
            word.last  = (pos >= run.size());
            expected_q.push_back(word);
         end
      endfunction

      function void check_result(logic [lzss_pkg::OUT_W-1:0] got_bytes,
                                 logic [lzss_pkg::CNT_W-1:0] got_count,
                                 logic got_last);
         decoded_word_type want;
         if (expected_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("Unexpected response transaction: bytes=%h count=%0d last=%b",
                        got_bytes, got_count, got_last);
            end
            return;
         end
         want = expected_q.pop_front();
         if (got_bytes !== want.bytes || got_count !== want.count || got_last !== want.last) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("Response mismatch: expected bytes=%h count=%0d last=%b",
                        want.bytes, want.count, want.last);
               $display("                   actual   bytes=%h count=%0d last=%b",
                        got_bytes, got_count, got_last);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lzss_req_if req_chan ();
   lzss_rsp_if rsp_chan ();

   lzss_token_stream_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lzss_decode_scoreboard board;
   bit [7:0]              stream_q [$];
   int unsigned           stream_written;
   int unsigned           idle_pct;
   int unsigned           cycle_count;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void add_literal(bit [7:0] value);
      stream_q.push_back(value);
      stream_written++;
   endfunction

   function automatic void add_match(int unsigned dist_m1, bit wrap, bit [7:0] len_byte);
      bit [15:0] raw;
      raw = {wrap, 15'(dist_m1)};
      stream_q.push_back(raw[7:0]);
      stream_q.push_back(raw[15:8]);
      stream_q.push_back(len_byte);
      stream_written += int'(len_byte) + int'(lzss_pkg::MIN_MATCH);
   endfunction

   function automatic bit [7:0] pick_length();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 8'hFF;
      if (roll == 1) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 15));
   endfunction

   function automatic int unsigned pick_distance();
      int unsigned reach;
      int unsigned roll;
      reach = (stream_written > lzss_pkg::HISTORY_DEPTH) ? lzss_pkg::HISTORY_DEPTH
                                                         : stream_written;
      roll  = $urandom_range(0, 5);
      if (roll == 5) return reach - 1;
      if (roll == 4) return $urandom_range(0, reach - 1);
      return $urandom_range(0, (reach > 16) ? 15 : reach - 1);
   endfunction

   function automatic void add_group();
      bit [7:0] flags;
      flags = 8'($urandom);
      if (stream_written == 0) flags[0] = 1'b1;
      stream_q.push_back(flags);
      for (int i = 0; i < lzss_pkg::GROUP_TOKENS; i++) begin
         if (flags[i]) add_literal(8'($urandom));
         else add_match(pick_distance(), 1'($urandom_range(0, 1)), pick_length());
      end
   endfunction

   function automatic void build_stream();
      stream_written = 0;
      stream_q.push_back(8'hC3);
      add_literal(8'h00);
      add_literal(8'hFF);
      add_match(0, 1'b0, 8'h00);
      add_match(1, 1'b1, 8'hFF);
      add_match(stream_written - 1, 1'b0, 8'h05);
      add_match(2, 1'b1, 8'h08);
      add_literal(8'hA5);
      add_literal(8'h5A);
      stream_q.push_back(8'hFF);
      add_literal(8'h80);
      add_literal(8'h7F);
      for (int i = 0; i < 6; i++) add_literal(8'($urandom));
      while (stream_q.size() < STREAM_TARGET - 3) add_group();
      // The stream ends inside a short group, partway through a match token.
      stream_q.push_back(8'h00);
      stream_q.push_back(8'($urandom));
      stream_q.push_back(8'($urandom));
   endfunction

   task automatic drive_stream();
      for (int idx = 0; idx < stream_q.size(); idx++) begin
         if (idx % 20 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 20;
               default: idle_pct = 50;
            endcase
         end
         if (stream_q.size() - idx <= CALM_TAIL) idle_pct = 0;
         @(negedge clock);
         if ($urandom_range(0, 99) < idle_pct) begin
            req_chan.valid     = 1'b0;
            req_chan.data_byte = 8'($urandom);
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         req_chan.valid     = 1'b1;
         req_chan.data_byte = stream_q[idx];
         do @(posedge clock); while (!req_chan.ready);
      end
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) < idle_pct) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) board.note_input(req_chan.data_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            board.check_result(rsp_chan.out_bytes, rsp_chan.byte_count, rsp_chan.last_of_run);
         end
      end
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      board              = new();
      reset              = 1'b1;
      idle_pct           = 0;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = 8'h00;
      build_stream();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      drive_stream();
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.error_count == 0 && board.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
